FILE: hdl/ivda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ivda_pkg
// Shared widths, codes and record types of the vector distance accumulator.
// ----------------------------------------------------------------------------
package ivda_pkg;

    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 32;  // a*b, signed
    localparam int SQ_DIFF_W  = 33;  // (a-b)^2, at most 2^32
    localparam int SQ_ELEM_W  = 31;  // a^2, at most 2^30
    localparam int METRIC_W   = 45;
    localparam int NORM_W     = 43;
    localparam int DOT_W      = 44;
    localparam int COUNT_W    = 13;
    localparam int SEL_W      = 2;

    localparam int IVDA_MAX_DIM_DEF = 4096;

    typedef enum logic [SEL_W-1:0] {
        METRIC_DOT    = 2'd0,
        METRIC_L2     = 2'd1,
        METRIC_NORM_A = 2'd2
    } t_metric;

    // One element pair after the multiplier stage.
    typedef struct packed {
        logic signed [PROD_W-1:0] ab;
        logic [SQ_DIFF_W-1:0]     sq_diff;
        logic [SQ_ELEM_W-1:0]     sq_a;
        logic [SQ_ELEM_W-1:0]     sq_b;
        logic                     last;
    } t_prod;

    // Totals including the current pair.
    typedef struct packed {
        logic signed [METRIC_W-1:0] metric;
        logic [NORM_W-1:0]          norm_a;
        logic [NORM_W-1:0]          norm_b;
        logic signed [DOT_W-1:0]    dot;
        logic [COUNT_W-1:0]         count;
        logic                       too_long;
    } t_res;

endpackage
`default_nettype wire

FILE: hdl/ivda_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ivda_in_if / ivda_out_if
// Valid/ready channels for element pairs in and vector results out.
// ----------------------------------------------------------------------------
interface ivda_in_if import ivda_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_element;

    modport source (output valid, elem_a, elem_b, last_element, input ready);
    modport sink   (input valid, elem_a, elem_b, last_element, output ready);
endinterface

interface ivda_out_if import ivda_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [METRIC_W-1:0] metric_value;
    logic [NORM_W-1:0]          norm_a_sum;
    logic [NORM_W-1:0]          norm_b_sum;
    logic signed [DOT_W-1:0]    dot_sum;
    logic [COUNT_W-1:0]         element_count;
    logic                       too_long;

    modport source (output valid, metric_value, norm_a_sum, norm_b_sum, dot_sum,
                    element_count, too_long, input ready);
    modport sink   (input valid, metric_value, norm_a_sum, norm_b_sum, dot_sum,
                    element_count, too_long, output ready);
endinterface
`default_nettype wire

FILE: hdl/int16_vector_distance_accumulator_unit.sv
`default_nettype none
// The marked pair passes the input, product and result registers before its result is valid.
// Throughput: one element pair per cycle; a pair is taken while a result waits,
// and the input stalls only when a marked pair meets a result not yet taken.
// Reset (synchronous, active low) clears the sums, count, flag, selector and
// all valid bits; the pipeline payload registers are not reset.
// ----------------------------------------------------------------------------
// int16_vector_distance_accumulator_unit
// Streams signed 16-bit element pairs and reports dot product, squared L2
// distance, squared norms and pair count per vector.
// ----------------------------------------------------------------------------
module int16_vector_distance_accumulator_unit import ivda_pkg::*; #(
    parameter int MAX_DIM = IVDA_MAX_DIM_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [SEL_W-1:0] i_cfg_wr_data,
    ivda_in_if.sink               i_in,
    ivda_out_if.source            o_out
);

    // Metric selector. It must be written only while the unit is idle, a rule on the user
    // that the block itself does not enforce, so the accumulate stage may read it directly.
    logic [SEL_W-1:0] r_metric_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric_sel <= METRIC_DOT;
        end else if (i_cfg_wr_en) begin
            r_metric_sel <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register. Each stage holds one beat and moves on
    // whenever the stage after it can take it, so bubbles close up and
    // only a marked pair facing a full result register stops the flow.
    // ------------------------------------------------------------------
    logic                     r_in_vld;
    logic signed [ELEM_W-1:0] r_a;
    logic signed [ELEM_W-1:0] r_b;
    logic                     r_last;

    logic  r_p_vld;
    t_prod r_prod;
    t_prod n_prod;

    logic  r_res_vld;
    t_res  r_res;
    t_res  w_tot;

    logic  w_res_free;
    logic  w_take;
    logic  w_s2_ready;
    logic  w_s1_ready;

    assign w_res_free = !r_res_vld || o_out.ready;
    assign w_take     = r_p_vld && (!r_prod.last || w_res_free);
    assign w_s2_ready = !r_p_vld || w_take;
    assign w_s1_ready = !r_in_vld || w_s2_ready;
    assign i_in.ready = w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_s1_ready) begin
            r_in_vld <= i_in.valid;
        end
        if (w_s1_ready && i_in.valid) begin
            r_a    <= i_in.elem_a;
            r_b    <= i_in.elem_b;
            r_last <= i_in.last_element;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four products. The difference needs 17 bits; its
    // square is at most 2^32 and always non-negative.
    // ------------------------------------------------------------------
    logic signed [ELEM_W:0]     w_diff;
    logic signed [2*ELEM_W+1:0] w_sq_diff;
    logic signed [2*ELEM_W-1:0] w_sq_a;
    logic signed [2*ELEM_W-1:0] w_sq_b;

    always_comb begin
        w_diff         = {r_a[ELEM_W-1], r_a} - {r_b[ELEM_W-1], r_b};
        w_sq_diff      = w_diff * w_diff;
        w_sq_a         = r_a * r_a;
        w_sq_b         = r_b * r_b;
        n_prod.ab      = r_a * r_b;
        n_prod.sq_diff = w_sq_diff[SQ_DIFF_W-1:0];
        n_prod.sq_a    = w_sq_a[SQ_ELEM_W-1:0];
        n_prod.sq_b    = w_sq_b[SQ_ELEM_W-1:0];
        n_prod.last    = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_s2_ready) begin
            r_p_vld <= r_in_vld;
        end
        if (w_s2_ready && r_in_vld) begin
            r_prod <= n_prod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: accumulate. The totals including the current pair are
    // formed combinationally and captured as the result on a marked pair.
    // ------------------------------------------------------------------
    ivda_acc #(
        .MAX_DIM (MAX_DIM)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_prod       (r_prod),
        .i_metric_sel (r_metric_sel),
        .o_res        (w_tot)
    );

    // Result register: it keeps a finished result while unmarked pairs
    // continue to accumulate behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_take && r_prod.last) begin
            r_res_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_res_vld <= 1'b0;
        end
        if (w_take && r_prod.last) begin
            r_res <= w_tot;
        end
    end

    assign o_out.valid         = r_res_vld;
    assign o_out.metric_value  = r_res.metric;
    assign o_out.norm_a_sum    = r_res.norm_a;
    assign o_out.norm_b_sum    = r_res.norm_b;
    assign o_out.dot_sum       = r_res.dot;
    assign o_out.element_count = r_res.count;
    assign o_out.too_long      = r_res.too_long;

    // The input may only stall because a result is waiting downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_res_vld && !o_out.ready))
        else $error("input stalled without a pending result");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && r_prod.last |=> r_res_vld)
        else $error("marked pair did not produce a result");

    a_too_long_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.too_long |-> o_out.element_count == COUNT_W'(MAX_DIM))
        else $error("overflowed vector reports a count other than the maximum");

endmodule
`default_nettype wire

FILE: hdl/ivda_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ivda_acc
// Accumulators, pair counter and overflow flag; forms the running totals.
// ----------------------------------------------------------------------------
module ivda_acc import ivda_pkg::*; #(
    parameter int MAX_DIM = IVDA_MAX_DIM_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire t_prod            i_prod,
    input  wire logic [SEL_W-1:0] i_metric_sel,
    output t_res                  o_res
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic signed [DOT_W-1:0]    r_dot, n_dot;
    logic [METRIC_W-1:0]        r_l2, n_l2;
    logic [NORM_W-1:0]          r_na, n_na;
    logic [NORM_W-1:0]          r_nb, n_nb;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_ovf, n_ovf;
    logic [CNT_W+COUNT_W-1:0]   w_cnt_ext;
    logic                       w_full;

    assign w_full = (r_cnt == CNT_W'(MAX_DIM));

    always_comb begin
        n_dot = r_dot;
        n_l2  = r_l2;
        n_na  = r_na;
        n_nb  = r_nb;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (w_full) begin
            n_ovf = 1'b1;
        end else begin
            n_dot = r_dot + {{(DOT_W-PROD_W){i_prod.ab[PROD_W-1]}}, i_prod.ab};
            n_l2  = r_l2 + METRIC_W'(i_prod.sq_diff);
            n_na  = r_na + NORM_W'(i_prod.sq_a);
            n_nb  = r_nb + NORM_W'(i_prod.sq_b);
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    assign w_cnt_ext = {COUNT_W'(0), n_cnt};

    always_comb begin
        o_res.norm_a   = n_na;
        o_res.norm_b   = n_nb;
        o_res.dot      = n_dot;
        o_res.count    = w_cnt_ext[COUNT_W-1:0];
        o_res.too_long = n_ovf;
        unique case (i_metric_sel)
            METRIC_DOT:    o_res.metric = {n_dot[DOT_W-1], n_dot};
            METRIC_L2:     o_res.metric = n_l2;
            METRIC_NORM_A: o_res.metric = METRIC_W'(n_na);
            default:       o_res.metric = '0;
        endcase
    end

    // The marked pair closes the vector: totals go out and the sums restart.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_l2  <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_take) begin
            if (i_prod.last) begin
                r_dot <= '0;
                r_l2  <= '0;
                r_na  <= '0;
                r_nb  <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_dot <= n_dot;
                r_l2  <= n_l2;
                r_na  <= n_na;
                r_nb  <= n_nb;
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIM))
        else $error("pair counter ran past the maximum length");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> w_full)
        else $error("overflow flag set before the counter reached the maximum");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_prod.last |=> (r_cnt == '0) && !r_ovf)
        else $error("sums not cleared after the last pair");

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the int16 vector distance accumulator. Element pairs
// go in through a valid/ready channel and vector results come back on another.
// A bench-side mirror of the sums predicts each result not typed into the table;
// each result beat is compared field by field against the oldest expected result.
// The run starts with a table of directed vectors and ends with random vectors.
// ----------------------------------------------------------------------------
module tb;
    import ivda_pkg::*;

    localparam int           DIM_LIMIT     = IVDA_MAX_DIM_DEF;
    localparam int           NO_WRITE      = -1;
    localparam logic [1:0]   METRIC_UNUSED = 2'd3;
    localparam int           SETTLE_CYCLES = 8;
    localparam int           PHASE_PAIRS   = 80;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [SEL_W-1:0] i_cfg_wr_data;

    ivda_in_if  pairs_if ();
    ivda_out_if results_if ();

    int16_vector_distance_accumulator_unit #(
        .MAX_DIM(DIM_LIMIT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in         (pairs_if),
        .o_out        (results_if)
    );

    // One row of the directed table. A row repeats its pair reps times; the
    // expected result is typed in only where it is obvious from the inputs.
    typedef struct {
        int                sel_wr;
        logic signed [15:0] a;
        logic signed [15:0] b;
        bit                last;
        int                reps;
        bit                typed;
        t_res              want;
    } t_stim_row;

    t_stim_row stim_rows[$];
    t_res      pending_results[$];
    t_res      head_result;
    int        fault_count;
    bit        calm;
    int        ready_hold;

    // Mirror of the block's sums, count, overflow flag and selector.
    logic [DOT_W-1:0]    acc_dot;
    logic [METRIC_W-1:0] acc_l2;
    logic [NORM_W-1:0]   acc_norm_a;
    logic [NORM_W-1:0]   acc_norm_b;
    int                  pair_count;
    bit                  too_long_seen;
    logic [SEL_W-1:0]    metric_mirror;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Adds one pair to the mirrored sums. Returns 1 with the vector result
    // when the pair is marked last, after which the sums start over.
    function automatic bit accumulate_pair(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input bit last, output t_res res);
        longint diff;
        res = '0;
        if (pair_count >= DIM_LIMIT) begin
            // Pairs beyond the limit are dropped but remembered by the flag.
            too_long_seen = 1'b1;
        end else begin
            diff       = longint'(a) - longint'(b);
            acc_dot    = acc_dot + DOT_W'(longint'(a) * longint'(b));
            acc_l2     = acc_l2 + METRIC_W'(diff * diff);
            acc_norm_a = acc_norm_a + NORM_W'(longint'(a) * longint'(a));
            acc_norm_b = acc_norm_b + NORM_W'(longint'(b) * longint'(b));
            pair_count++;
        end
        if (!last) return 1'b0;
        case (metric_mirror)
            METRIC_DOT:    res.metric = {acc_dot[DOT_W-1], acc_dot};
            METRIC_L2:     res.metric = acc_l2;
            METRIC_NORM_A: res.metric = {2'b00, acc_norm_a};
            default:       res.metric = '0;
        endcase
        res.norm_a   = acc_norm_a;
        res.norm_b   = acc_norm_b;
        res.dot      = acc_dot;
        res.count    = COUNT_W'(pair_count);
        res.too_long = too_long_seen;
        acc_dot       = '0;
        acc_l2        = '0;
        acc_norm_a    = '0;
        acc_norm_b    = '0;
        pair_count    = 0;
        too_long_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic mismatch(input string what, input logic signed [63:0] want,
                            input logic signed [63:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) mismatch(name, want, got);
    endtask

    task automatic add_row(input int sel_wr, input int a, input int b, input bit last,
                           input int reps, input bit typed, input longint metric,
                           input longint norm_a, input longint norm_b,
                           input longint dot, input int count, input bit too_long);
        t_stim_row r;
        r.sel_wr        = sel_wr;
        r.a             = 16'(a);
        r.b             = 16'(b);
        r.last          = last;
        r.reps          = reps;
        r.typed         = typed;
        r.want.metric   = METRIC_W'(metric);
        r.want.norm_a   = NORM_W'(norm_a);
        r.want.norm_b   = NORM_W'(norm_b);
        r.want.dot      = DOT_W'(dot);
        r.want.count    = COUNT_W'(count);
        r.want.too_long = too_long;
        stim_rows.push_back(r);
    endtask

    // Sends one pair, with an occasional idle burst ahead of it, and records
    // the predicted result once the beat is taken.
    task automatic feed(input logic signed [15:0] a, input logic signed [15:0] b,
                        input bit last, input bit typed, input t_res want);
        t_res predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            pairs_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        pairs_if.valid        <= 1'b1;
        pairs_if.elem_a       <= a;
        pairs_if.elem_b       <= b;
        pairs_if.last_element <= last;
        @(posedge i_clk);
        while (!pairs_if.ready) @(posedge i_clk);
        if (accumulate_pair(a, b, last, predicted))
            pending_results.push_back(typed ? want : predicted);
    endtask

    // Holds the input until every predicted result has come back, then lets
    // the pipeline settle, since unmarked pairs may still be in flight.
    task automatic drain();
        pairs_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_metric_select(input logic [SEL_W-1:0] sel);
        i_cfg_wr_data <= sel;
        i_cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        metric_mirror = sel;
    endtask

    // Result side: ready drops in random bursts, except in the calm phase.
    always @(posedge i_clk) begin
        if (calm) begin
            results_if.ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            results_if.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 7);
            results_if.ready <= 1'b0;
        end else begin
            results_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && results_if.valid && results_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatch("unexpected result beat, dot_sum", 0, results_if.dot_sum);
            end else begin
                head_result = pending_results.pop_front();
                check_field("metric_value", head_result.metric, results_if.metric_value);
                check_field("norm_a_sum", head_result.norm_a, results_if.norm_a_sum);
                check_field("norm_b_sum", head_result.norm_b, results_if.norm_b_sum);
                check_field("dot_sum", head_result.dot, results_if.dot_sum);
                check_field("element_count", head_result.count, results_if.element_count);
                check_field("too_long", head_result.too_long, results_if.too_long);
            end
        end
    end

    initial begin
        t_res        blank;
        int          len;
        int          sent;
        logic [1:0]  sel;

        i_rst_n               = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_wr_data         = '0;
        pairs_if.valid        = 1'b0;
        pairs_if.elem_a       = '0;
        pairs_if.elem_b       = '0;
        pairs_if.last_element = 1'b0;
        results_if.ready      = 1'b0;
        fault_count           = 0;
        calm                  = 1'b0;
        ready_hold            = 0;
        blank                 = '0;
        acc_dot               = '0;
        acc_l2                = '0;
        acc_norm_a            = '0;
        acc_norm_b            = '0;
        pair_count            = 0;
        too_long_seen         = 1'b0;
        metric_mirror         = METRIC_DOT;

        // Single pair right after reset, dot product selected by default.
        add_row(NO_WRITE, 0, 0, 1, 1, 1, 0, 0, 0, 0, 1, 0);
        // Full-length vector of the most negative element: largest sums.
        add_row(NO_WRITE, -32768, -32768, 0, DIM_LIMIT - 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(NO_WRITE, -32768, -32768, 1, 1, 1, 64'sd4398046511104,
                64'sd4398046511104, 64'sd4398046511104, 64'sd4398046511104,
                DIM_LIMIT, 0);
        // Overlong vector of opposite extremes: largest distance, most
        // negative dot product, and the overflow flag.
        add_row(METRIC_L2, -32768, 32767, 0, DIM_LIMIT + 3, 0, 0, 0, 0, 0, 0, 0);
        add_row(NO_WRITE, -32768, 32767, 1, 1, 1, 64'sd17591649177600,
                64'sd4398046511104, 64'sd4397778079744, -64'sd4397912293376,
                DIM_LIMIT, 1);
        add_row(METRIC_NORM_A, 32767, -32768, 1, 1, 1, 64'sd1073676289,
                64'sd1073676289, 64'sd1073741824, -64'sd1073709056, 1, 0);
        // Unused selector value reports a zero metric.
        add_row(METRIC_UNUSED, 5, -3, 1, 1, 1, 0, 25, 9, -15, 1, 0);
        add_row(METRIC_DOT, -1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(NO_WRITE, 1, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(NO_WRITE, -1, -1, 1, 1, 0, 0, 0, 0, 0, 0, 0);
        // Exactly at the limit, then a marked pair that must be dropped.
        add_row(NO_WRITE, 100, -7, 0, DIM_LIMIT, 0, 0, 0, 0, 0, 0, 0);
        add_row(NO_WRITE, 32767, 32767, 1, 1, 0, 0, 0, 0, 0, 0, 0);
        // Back-to-back one-pair vectors keep a result waiting at the output.
        add_row(NO_WRITE, 7, 9, 1, 5, 0, 0, 0, 0, 0, 0, 0);
        add_row(METRIC_L2, 32767, -32768, 0, 2, 0, 0, 0, 0, 0, 0, 0);
        add_row(NO_WRITE, -12345, 23456, 1, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(METRIC_NORM_A, -32768, 0, 0, 3, 0, 0, 0, 0, 0, 0, 0);
        add_row(NO_WRITE, 1, 32767, 1, 1, 0, 0, 0, 0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].sel_wr != NO_WRITE) begin
                drain();
                write_metric_select(SEL_W'(stim_rows[i].sel_wr));
            end
            repeat (stim_rows[i].reps)
                feed(stim_rows[i].a, stim_rows[i].b, stim_rows[i].last,
                     stim_rows[i].typed, stim_rows[i].want);
        end

        // Random vectors, mostly short, in phases with the selector written anew for each;
        // the last phase runs without any idling on either side.
        for (int p = 0; p < 5; p++) begin
            drain();
            case (p)
                0:       sel = METRIC_L2;
                1:       sel = METRIC_UNUSED;
                2:       sel = METRIC_NORM_A;
                3:       sel = 2'($urandom_range(0, 3));
                default: sel = METRIC_DOT;
            endcase
            write_metric_select(sel);
            calm = (p == 4);
            sent = 0;
            while (sent < PHASE_PAIRS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(1, 12);
                for (int j = 0; j < len; j++)
                    feed(pick_elem(), pick_elem(), j == len - 1, 1'b0, blank);
                sent += len;
            end
        end

        drain();
        if (fault_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
